### src/ssp8_pkg.sv
// Package: shared types and constants of the 8-bit serial shift port.
`timescale 1ns / 1ps
`default_nettype none

package ssp8_pkg;

  // Item kinds carried in s_axis_tuser[1:0]
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } opcode_t;

  // Register selector carried in s_axis_tuser[2]
  typedef enum logic {
    SEL_DATA = 1'b0,
    SEL_CTRL = 1'b1
  } reg_sel_t;

  localparam int BYTE_W   = 8;
  localparam int CD_W     = 10;
  localparam int CD_WIDE_W = CD_W + 1;
  localparam int STEP_W   = 4;

  localparam int STEP_CYCLES    = 122;
  localparam int STEPS_PER_BYTE = 8;

  localparam int CTRL_START_BIT = 7;
  localparam int CTRL_CLK_BIT   = 0;

  localparam int CD_MIN_INT = -(1 << (CD_W - 1));
  localparam int CD_MAX_INT = (1 << (CD_W - 1)) - 1;

  typedef logic signed [CD_W-1:0]      cd_t;
  typedef logic signed [CD_WIDE_W-1:0] cd_wide_t;
  typedef logic [STEP_W-1:0]           step_cnt_t;
  typedef logic [BYTE_W-1:0]           byte_t;

  localparam cd_t       CD_RELOAD   = cd_t'(STEP_CYCLES);
  localparam cd_wide_t  CDW_RELOAD  = cd_wide_t'(STEP_CYCLES);
  localparam cd_wide_t  CDW_MIN     = cd_wide_t'(CD_MIN_INT);
  localparam cd_wide_t  CDW_MAX     = cd_wide_t'(CD_MAX_INT);
  localparam step_cnt_t STEPS_START = step_cnt_t'(STEPS_PER_BYTE);

  // Result word fields
  typedef struct packed {
    logic  shifted_bit;
    logic  transfer_done;
    byte_t read_data;
  } result_t;

endpackage

`default_nettype wire

### src/serial_shift_port_8bit.sv
// Top level: 8-bit serial shift port with data and control registers.
//
//  Channel  | Direction | tdata (low bit up)                         | tuser
//  s_axis   | in        | write_data[7:0], elapsed_cycles[15:8]      | opcode[1:0], reg_select[2]
//  m_axis   | out       | read_data[7:0], transfer_done[8],          | -
//           |           | shifted_bit[9], zeros[15:10]               |
//
//  One word per cycle sustained unless m_axis stalls; a result is offered on m_axis once its
//  word passes the input register, then the result register, set by the single update stage.
//  rst clears the port state, the countdown and both valid flags.
//  A stall on m_axis holds the result register; the input register still takes one
//  more word, then s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module serial_shift_port_8bit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // write_data[7:0], elapsed_cycles[15:8]
  input  wire logic [2:0]  s_axis_tuser,   // opcode[1:0], reg_select[2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata    // read_data[7:0], transfer_done[8],
                                           // shifted_bit[9], zero fill[15:10]
);

  // Input register
  logic                    in_valid;
  ssp8_pkg::opcode_t       in_opcode;
  ssp8_pkg::reg_sel_t      in_sel;
  ssp8_pkg::byte_t         in_wdata;
  ssp8_pkg::byte_t         in_cycles;

  // Result register
  logic                    out_valid;
  ssp8_pkg::result_t       res;

  // Port state
  ssp8_pkg::byte_t         send_byte;
  ssp8_pkg::byte_t         received_byte;
  logic                    start_flag;
  logic                    internal_clock;
  logic                    busy;
  ssp8_pkg::cd_t           cycle_countdown;
  ssp8_pkg::step_cnt_t     steps_left;
  ssp8_pkg::byte_t         out_shift;
  ssp8_pkg::byte_t         in_shift;

  ssp8_pkg::byte_t         send_byte_next;
  ssp8_pkg::byte_t         received_byte_next;
  logic                    start_flag_next;
  logic                    internal_clock_next;
  logic                    busy_next;
  ssp8_pkg::cd_t           cycle_countdown_next;
  ssp8_pkg::step_cnt_t     steps_left_next;
  ssp8_pkg::byte_t         out_shift_next;
  ssp8_pkg::byte_t         in_shift_next;
  ssp8_pkg::result_t       res_next;

  logic                    advance;
  logic                    s_fire;
  logic                    start_now;
  logic                    step;
  ssp8_pkg::cd_t           cd_base;
  ssp8_pkg::cd_wide_t      cd_sub;
  ssp8_pkg::cd_wide_t      cd_sub_sat;
  ssp8_pkg::cd_wide_t      cd_add;
  ssp8_pkg::cd_wide_t      cd_add_sat;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b000000, res};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_opcode <= ssp8_pkg::opcode_t'(s_axis_tuser[1:0]);
      in_sel    <= ssp8_pkg::reg_sel_t'(s_axis_tuser[2]);
      in_wdata  <= s_axis_tdata[7:0];
      in_cycles <= s_axis_tdata[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_byte       <= '0;
      received_byte   <= '0;
      start_flag      <= 1'b0;
      internal_clock  <= 1'b0;
      busy            <= 1'b0;
      cycle_countdown <= '0;
      steps_left      <= '0;
      out_shift       <= '0;
      in_shift        <= '0;
    end else if (advance) begin
      send_byte       <= send_byte_next;
      received_byte   <= received_byte_next;
      start_flag      <= start_flag_next;
      internal_clock  <= internal_clock_next;
      busy            <= busy_next;
      cycle_countdown <= cycle_countdown_next;
      steps_left      <= steps_left_next;
      out_shift       <= out_shift_next;
      in_shift        <= in_shift_next;
    end
  end

  // Countdown path: load on start, subtract elapsed cycles, floor, add the reload value on a step and cap
  assign start_now  = start_flag && !busy;
  assign cd_base    = start_now ? ssp8_pkg::CD_RELOAD : cycle_countdown;
  assign cd_sub     = $signed({cd_base[ssp8_pkg::CD_W-1], cd_base})
                    - $signed({3'b000, in_cycles});
  assign cd_sub_sat = (cd_sub < ssp8_pkg::CDW_MIN) ? ssp8_pkg::CDW_MIN : cd_sub;
  assign cd_add     = cd_sub_sat + ssp8_pkg::CDW_RELOAD;
  assign cd_add_sat = (cd_add > ssp8_pkg::CDW_MAX) ? ssp8_pkg::CDW_MAX : cd_add;

  always_comb begin
    send_byte_next       = send_byte;
    received_byte_next   = received_byte;
    start_flag_next      = start_flag;
    internal_clock_next  = internal_clock;
    busy_next            = busy;
    cycle_countdown_next = cycle_countdown;
    steps_left_next      = steps_left;
    out_shift_next       = out_shift;
    in_shift_next        = in_shift;
    res_next             = '0;
    step                 = 1'b0;

    unique case (in_opcode)
      ssp8_pkg::OP_TICK: begin
        if (start_now) begin
          busy_next            = 1'b1;
          steps_left_next      = ssp8_pkg::STEPS_START;
          cycle_countdown_next = ssp8_pkg::CD_RELOAD;
          out_shift_next       = send_byte;
          in_shift_next        = '0;
        end
        if (start_now || busy) begin
          if (internal_clock) begin
            cycle_countdown_next = cd_sub_sat[ssp8_pkg::CD_W-1:0];
            step = (cd_sub_sat <= 0);
          end
          if (step) begin
            // rotate out the top bit, shift a zero into the incoming byte
            res_next.shifted_bit = out_shift_next[ssp8_pkg::BYTE_W-1];
            out_shift_next = {out_shift_next[ssp8_pkg::BYTE_W-2:0],
                              out_shift_next[ssp8_pkg::BYTE_W-1]};
            in_shift_next  = {in_shift_next[ssp8_pkg::BYTE_W-2:0], 1'b0};
            cycle_countdown_next = cd_add_sat[ssp8_pkg::CD_W-1:0];
            if (steps_left_next != '0) begin
              steps_left_next = steps_left_next - 1'b1;
            end
          end
          if (steps_left_next == '0) begin
            received_byte_next     = in_shift_next;
            busy_next              = 1'b0;
            start_flag_next        = 1'b0;
            res_next.transfer_done = 1'b1;
          end
        end
      end
      ssp8_pkg::OP_READ: begin
        if (in_sel == ssp8_pkg::SEL_DATA) begin
          res_next.read_data = received_byte;
        end else begin
          res_next.read_data[ssp8_pkg::CTRL_START_BIT] = start_flag;
          res_next.read_data[ssp8_pkg::CTRL_CLK_BIT]   = internal_clock;
        end
      end
      ssp8_pkg::OP_WRITE: begin
        if (in_sel == ssp8_pkg::SEL_DATA) begin
          send_byte_next = in_wdata;
        end else begin
          start_flag_next     = in_wdata[ssp8_pkg::CTRL_START_BIT];
          internal_clock_next = in_wdata[ssp8_pkg::CTRL_CLK_BIT];
        end
      end
      default: begin
        // unused code: no state change, zero result
      end
    endcase
  end

  // A transfer in flight always has steps left, and an idle port has none
  a_busy_steps: assert property (@(posedge clk) disable iff (rst)
    busy == (steps_left != '0))
    else $error("busy flag and step count disagree");

  a_steps_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (steps_left <= ssp8_pkg::STEPS_START))
    else $error("step count above one byte");

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && res_next.transfer_done) |=> (!busy && !start_flag))
    else $error("completion left start or busy set");

  a_nontick_quiet: assert property (@(posedge clk) disable iff (rst)
    (advance && in_opcode != ssp8_pkg::OP_TICK) |=>
      (!res.transfer_done && !res.shifted_bit))
    else $error("register access raised a tick flag");

  a_cd_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cycle_countdown <= ssp8_pkg::CD_RELOAD))
    else $error("countdown above reload value");

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for the 8-bit serial shift port: random stream stimulus and a cycle-free predictor.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [1:0]         op;
    ssp8_pkg::reg_sel_t sel;
    ssp8_pkg::byte_t    wdata;
    ssp8_pkg::byte_t    cycles;
  } port_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // write_data[7:0], elapsed_cycles[15:8]
  logic [2:0]  s_axis_tuser = '0;   // opcode[1:0], reg_select[2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // read_data[7:0], transfer_done[8], shifted_bit[9]

  serial_shift_port_8bit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow state of the port
  ssp8_pkg::byte_t     sh_send_byte = '0;
  ssp8_pkg::byte_t     sh_rx_byte = '0;
  logic                sh_start = 1'b0;
  logic                sh_int_clk = 1'b0;
  logic                sh_busy = 1'b0;
  int                  sh_countdown = 0;
  ssp8_pkg::step_cnt_t sh_steps = '0;
  ssp8_pkg::byte_t     sh_out = '0;
  ssp8_pkg::byte_t     sh_in = '0;

  port_word_t          word_q[$];
  ssp8_pkg::result_t   expected_q[$];

  int mismatches = 0;
  int words_in = 0;
  int results_in = 0;
  int steps_taken = 0;
  int transfers_done = 0;
  int idle_cycles = 0;

  bit tx_gaps_on = 1'b1;
  bit rx_stall_on = 1'b1;
  int hold_req = 0;
  int hold_seen = 0;
  int rx_wait = 0;
  int tx_gap = 0;
  bit tx_taken = 1'b0;
  port_word_t tx_word;

  port_word_t        acc_word;
  ssp8_pkg::result_t want;
  ssp8_pkg::result_t got;

  function automatic int clamp_countdown(input int v);
    if (v < ssp8_pkg::CD_MIN_INT) return ssp8_pkg::CD_MIN_INT;
    if (v > ssp8_pkg::CD_MAX_INT) return ssp8_pkg::CD_MAX_INT;
    return v;
  endfunction

  // Update the shadow state for one accepted word and return its result
  function automatic ssp8_pkg::result_t predict_port_result(input port_word_t w);
    ssp8_pkg::result_t r;
    logic              step;
    r = '0;
    step = 1'b0;
    case (w.op)
      ssp8_pkg::OP_TICK: begin
        if (sh_start && !sh_busy) begin
          sh_busy = 1'b1;
          sh_steps = ssp8_pkg::STEPS_START;
          sh_countdown = ssp8_pkg::STEP_CYCLES;
          sh_out = sh_send_byte;
          sh_in = '0;
        end
        if (sh_busy) begin
          if (sh_int_clk) begin
            sh_countdown = clamp_countdown(sh_countdown - int'(w.cycles));
            step = (sh_countdown <= 0);
          end
          if (step) begin
            r.shifted_bit = sh_out[ssp8_pkg::BYTE_W-1];
            sh_out = {sh_out[ssp8_pkg::BYTE_W-2:0], sh_out[ssp8_pkg::BYTE_W-1]};
            sh_in = {sh_in[ssp8_pkg::BYTE_W-2:0], 1'b0};
            sh_countdown = clamp_countdown(sh_countdown + ssp8_pkg::STEP_CYCLES);
            if (sh_steps > 0) sh_steps = sh_steps - 1'b1;
            steps_taken++;
          end
          if (sh_steps == 0) begin
            sh_rx_byte = sh_in;
            sh_busy = 1'b0;
            sh_start = 1'b0;
            r.transfer_done = 1'b1;
          end
        end
      end
      ssp8_pkg::OP_READ: begin
        if (w.sel == ssp8_pkg::SEL_DATA) begin
          r.read_data = sh_rx_byte;
        end else begin
          r.read_data = '0;
          r.read_data[ssp8_pkg::CTRL_START_BIT] = sh_start;
          r.read_data[ssp8_pkg::CTRL_CLK_BIT] = sh_int_clk;
        end
      end
      ssp8_pkg::OP_WRITE: begin
        if (w.sel == ssp8_pkg::SEL_DATA) begin
          sh_send_byte = w.wdata;
        end else begin
          sh_start = w.wdata[ssp8_pkg::CTRL_START_BIT];
          sh_int_clk = w.wdata[ssp8_pkg::CTRL_CLK_BIT];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got_v, want_v);
  endtask

  function automatic int pick_gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Elapsed cycles for a tick: mostly enough for one step
  function automatic ssp8_pkg::byte_t tick_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return ssp8_pkg::byte_t'($urandom_range(ssp8_pkg::STEP_CYCLES, 255));
    if (r < 85) return ssp8_pkg::byte_t'($urandom_range(0, ssp8_pkg::STEP_CYCLES - 1));
    return ssp8_pkg::byte_t'($urandom);
  endfunction

  task automatic push_word(input logic [1:0] op, input ssp8_pkg::reg_sel_t sel,
                           input ssp8_pkg::byte_t wdata, input ssp8_pkg::byte_t cycles);
    port_word_t w;
    w.op = op;
    w.sel = sel;
    w.wdata = wdata;
    w.cycles = cycles;
    word_q.push_back(w);
  endtask

  task automatic push_tick(input ssp8_pkg::byte_t cycles);
    push_word(ssp8_pkg::OP_TICK, ssp8_pkg::reg_sel_t'($urandom_range(0, 1)),
              ssp8_pkg::byte_t'($urandom), cycles);
  endtask

  task automatic push_read(input ssp8_pkg::reg_sel_t sel);
    push_word(ssp8_pkg::OP_READ, sel, ssp8_pkg::byte_t'($urandom),
              ssp8_pkg::byte_t'($urandom));
  endtask

  task automatic push_write(input ssp8_pkg::reg_sel_t sel, input ssp8_pkg::byte_t data);
    push_word(ssp8_pkg::OP_WRITE, sel, data, ssp8_pkg::byte_t'($urandom));
  endtask

  // One transfer: load data, set start, then ticks with reads and the odd control or data poke
  task automatic queue_transfer(input bit slow);
    ssp8_pkg::byte_t ctrl;
    int n;
    ctrl = ssp8_pkg::byte_t'($urandom);
    ctrl[ssp8_pkg::CTRL_START_BIT] = 1'b1;
    ctrl[ssp8_pkg::CTRL_CLK_BIT] = ($urandom_range(0, 9) != 0);
    push_write(ssp8_pkg::SEL_DATA, ssp8_pkg::byte_t'($urandom));
    push_write(ssp8_pkg::SEL_CTRL, ctrl);
    n = slow ? $urandom_range(12, 30) : $urandom_range(8, 12);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0) push_read(ssp8_pkg::reg_sel_t'($urandom_range(0, 1)));
      if ($urandom_range(0, 14) == 0)
        push_write(ssp8_pkg::SEL_CTRL, ssp8_pkg::byte_t'($urandom));
      if ($urandom_range(0, 14) == 0)
        push_write(ssp8_pkg::SEL_DATA, ssp8_pkg::byte_t'($urandom));
      push_tick(slow ? ssp8_pkg::byte_t'($urandom_range(0, 60)) : tick_cycles());
    end
    push_read(ssp8_pkg::SEL_CTRL);
    push_read(ssp8_pkg::SEL_DATA);
  endtask

  task automatic queue_random(input int n);
    int r;
    int target;
    target = word_q.size() + n;
    while (word_q.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        queue_transfer(1'b0);
      end else if (r < 80) begin
        queue_transfer(1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          push_word(2'($urandom_range(ssp8_pkg::OP_TICK, OP_UNUSED)),
                    ssp8_pkg::reg_sel_t'($urandom_range(0, 1)),
                    ssp8_pkg::byte_t'($urandom), ssp8_pkg::byte_t'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (word_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0) @(posedge clk);
  endtask

  // Sender: present the next word once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || tx_taken) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (word_q.size() != 0) begin
        tx_word = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {tx_word.cycles, tx_word.wdata};
        s_axis_tuser <= {tx_word.sel, tx_word.op};
        tx_gap <= (tx_gaps_on && $urandom_range(0, 99) < 30) ? pick_gap_len() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      rx_wait <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 99) < 20) begin
      rx_wait <= pick_gap_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tx_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;

      if (s_axis_tvalid && s_axis_tready) begin
        acc_word.op = s_axis_tuser[1:0];
        acc_word.sel = ssp8_pkg::reg_sel_t'(s_axis_tuser[2]);
        acc_word.wdata = s_axis_tdata[7:0];
        acc_word.cycles = s_axis_tdata[15:8];
        expected_q.push_back(predict_port_result(acc_word));
        words_in++;
      end

      if (m_axis_tvalid && m_axis_tready) begin
        results_in++;
        got = ssp8_pkg::result_t'(m_axis_tdata[9:0]);
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending", m_axis_tdata, 0);
        end else begin
          want = expected_q.pop_front();
          if (want.transfer_done) transfers_done++;
          if (got.read_data != want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
          if (got.transfer_done != want.transfer_done)
            report_mismatch("transfer_done", got.transfer_done, want.transfer_done);
          if (got.shifted_bit != want.shifted_bit)
            report_mismatch("shifted_bit", got.shifted_bit, want.shifted_bit);
          if (m_axis_tdata[15:10] != '0)
            report_mismatch("zero fill", m_axis_tdata[15:10], 0);
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("no word moved for %0d cycles", STALL_LIMIT);
    $display("[serial_shift_port_8bit] ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle reads and tick, a full fast transfer with countdown saturation,
    // then an external-clock start, start while busy, and the unused opcode
    push_read(ssp8_pkg::SEL_DATA);
    push_read(ssp8_pkg::SEL_CTRL);
    push_tick(8'd0);
    push_write(ssp8_pkg::SEL_DATA, 8'hA5);
    push_write(ssp8_pkg::SEL_CTRL, 8'hFF);
    push_read(ssp8_pkg::SEL_CTRL);
    repeat (8) push_tick(8'd255);
    push_read(ssp8_pkg::SEL_CTRL);
    push_read(ssp8_pkg::SEL_DATA);
    push_tick(8'd0);
    push_write(ssp8_pkg::SEL_CTRL, 8'h80);
    push_tick(8'd255);
    push_write(ssp8_pkg::SEL_CTRL, 8'h81);
    push_tick(8'd0);
    push_tick(8'd121);
    push_tick(8'd1);
    push_write(ssp8_pkg::SEL_DATA, 8'h00);
    push_word(OP_UNUSED, ssp8_pkg::SEL_CTRL, 8'hFF, 8'hFF);
    push_write(ssp8_pkg::SEL_CTRL, 8'h7E);
    push_read(ssp8_pkg::SEL_CTRL);
    wait_drained();

    queue_random(250);
    wait_drained();

    // Fill the port against a long receiver hold-off, then let it drain
    @(posedge clk);
    tx_gaps_on = 1'b0;
    hold_req = hold_req + 1;
    queue_random(40);
    wait_drained();

    rx_stall_on = 1'b0;
    queue_random(200);
    wait_drained();

    tx_gaps_on = 1'b1;
    rx_stall_on = 1'b1;
    queue_random(190);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d words and %0d results: %0d shift steps, %0d completed transfers",
             words_in, results_in, steps_taken, transfers_done);
    $display("idle reads, control writes, stalls and a long receiver hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("[serial_shift_port_8bit] OK");
    end else begin
      $display("[serial_shift_port_8bit] ERROR");
    end
    $finish;
  end

endmodule
